@@ hdl/pov_pkg.sv @@
// ----------------------------------------------------------------------------
// pov_pkg
// Shared types and constants of the scrolling column driver.
// ----------------------------------------------------------------------------
package pov_pkg;

  localparam int COLUMN_W  = 16;
  localparam int COUNTER_W = 16;
  localparam int SLOT_LEN_W = 10;
  localparam int DIVISOR_W = 11;
  localparam int DIV_STEPS = 16;
  localparam int STEP_W    = 4;

  localparam logic [COLUMN_W-1:0]   END_MARKER        = 16'h0A00;
  // a 15000-tick rotation split into 100 slots
  localparam logic [SLOT_LEN_W-1:0] RESET_SLOT_LENGTH = 10'd150;
  localparam logic [SLOT_LEN_W-1:0] SLOT_LENGTH_MAX   = 10'd1023;

  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_INDEX   = 3'd1;
  localparam logic [2:0] OP_SCROLL  = 3'd2;
  localparam logic [2:0] OP_WRITE   = 3'd3;
  localparam logic [2:0] OP_RESTART = 3'd4;

  typedef struct packed {
    logic [2:0]  operation;
    logic [8:0]  text_address;
    logic [15:0] text_word;
  } cmd_t;

  typedef struct packed {
    logic [15:0] led_column;
    logic [6:0]  slot_index;
  } res_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_START,
    S_DIV,
    S_EMIT
  } state_t;

endpackage

@@ hdl/pov_cell.sv @@
// ----------------------------------------------------------------------------
// pov_cell
// One column of the display window; takes its neighbor's column on a shift.
// ----------------------------------------------------------------------------
module pov_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          shift,
  input  logic [pov_pkg::COLUMN_W-1:0]  shift_in,
  output logic [pov_pkg::COLUMN_W-1:0]  value
);

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else if (shift) begin
      value <= shift_in;
    end
  end

endmodule

@@ hdl/pov_div.sv @@
// ----------------------------------------------------------------------------
// pov_div
// Serial restoring divider, one quotient bit per cycle, that also keeps the
// quotient reduced modulo a constant as its bits come out.
// ----------------------------------------------------------------------------
module pov_div #(
  parameter int MOD = 100
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [pov_pkg::COUNTER_W-1:0]  dividend,
  input  logic [pov_pkg::DIVISOR_W-1:0]  divisor,
  output logic                           done,
  output logic [((MOD > 1) ? $clog2(MOD) : 1)-1:0] quotient_mod
);

  localparam int MW = (MOD > 1) ? $clog2(MOD) : 1;

  logic                           busy;
  logic [pov_pkg::STEP_W-1:0]     step;
  logic [pov_pkg::COUNTER_W-1:0]  dvd;
  logic [pov_pkg::DIVISOR_W-1:0]  dvs;
  logic [pov_pkg::DIVISOR_W-1:0]  rem;

  logic [pov_pkg::DIVISOR_W:0]    shifted;
  logic                           qbit;
  logic [pov_pkg::DIVISOR_W-1:0]  rem_next;
  logic [MW:0]                    mod_shifted;
  logic [MW-1:0]                  mod_next;

  always_comb begin
    shifted     = {rem, dvd[pov_pkg::COUNTER_W-1]};
    qbit        = shifted >= {1'b0, dvs};
    rem_next    = qbit ? pov_pkg::DIVISOR_W'(shifted - {1'b0, dvs})
                       : shifted[pov_pkg::DIVISOR_W-1:0];
    // running remainder stays below MOD, so one subtract keeps it reduced
    mod_shifted = {quotient_mod, qbit};
    mod_next    = (mod_shifted >= (MW+1)'(MOD)) ? MW'(mod_shifted - (MW+1)'(MOD))
                                                : mod_shifted[MW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == pov_pkg::STEP_W'(pov_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd          <= dividend;
      dvs          <= divisor;
      rem          <= '0;
      quotient_mod <= '0;
    end else if (busy) begin
      dvd          <= {dvd[pov_pkg::COUNTER_W-2:0], 1'b0};
      rem          <= rem_next;
      quotient_mod <= mod_next;
    end
  end

endmodule

@@ hdl/pov_scrolling_column_driver.sv @@
// ----------------------------------------------------------------------------
// pov_scrolling_column_driver
// Persistence-of-vision column driver with a scrolling text window.
// ----------------------------------------------------------------------------
// One item at a time. After reset the text memory is cleared, one word a
// cycle, all TEXT_DEPTH words (512 by default), before the first item is
// taken. Every item ends with the slot computation in a serial divider that
// produces one quotient bit per cycle; the result of a tick, an index pulse,
// a write or an unknown operation is registered after the divider is done,
// and only then is the next item taken. The slot length of an index pulse
// comes from a multiply by the reciprocal of SLOT_COUNT in the accept cycle.
// A scroll step adds a text memory read, and a second one when it meets an
// end marker; a restart reads WINDOW_LEN words and reads again for each end
// marker it meets. The window is a row of cells that all shift at once; the
// result register lets the next item in while a result still waits to be
// taken, and the block then holds its finished result until it is.
module pov_scrolling_column_driver #(
  parameter int SLOT_COUNT   = 100,
  parameter int TEXT_DEPTH   = 512,
  parameter int WINDOW_FIRST = 30,
  parameter int WINDOW_LEN   = 30
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  pov_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_ready,
  output pov_pkg::res_t res
);

  localparam int AW = $clog2(TEXT_DEPTH);
  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int IW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int LW = $clog2(WINDOW_LEN + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TEXT_DEPTH - 1);
  // counter / SLOT_COUNT as a multiply by a rounded-up reciprocal, exact for
  // every counter value
  localparam int    LEN_SHIFT = pov_pkg::COUNTER_W + SW;
  localparam int    PROD_W    = 2 * pov_pkg::COUNTER_W + 1;
  localparam longint LEN_RECIP = (longint'(1) << LEN_SHIFT) / SLOT_COUNT + 1;

  pov_pkg::state_t state, state_next;

  logic [pov_pkg::COUNTER_W-1:0]  counter, counter_next;
  logic [pov_pkg::SLOT_LEN_W-1:0] slot_length, slot_length_next;
  logic [AW-1:0]                  text_position, text_position_next;
  logic [AW-1:0]                  fetch_addr, fetch_addr_next;
  logic [LW-1:0]                  fetch_left, fetch_left_next;
  logic [AW-1:0]                  clr_addr, clr_addr_next;
  logic                           res_valid_next;
  pov_pkg::res_t                  res_next;

  logic [pov_pkg::COLUMN_W-1:0]   text_mem [TEXT_DEPTH];
  logic                           mem_we;
  logic [AW-1:0]                  mem_waddr;
  logic [pov_pkg::COLUMN_W-1:0]   mem_wdata;
  logic                           rd_en;
  logic [AW-1:0]                  rd_addr;
  logic [pov_pkg::COLUMN_W-1:0]   rd_data;

  logic                           push;
  logic [pov_pkg::COLUMN_W-1:0]   cell_q [WINDOW_LEN];

  logic                           div_start;
  logic [pov_pkg::COUNTER_W-1:0]  div_dividend;
  logic [pov_pkg::DIVISOR_W-1:0]  div_divisor;
  logic                           div_done;
  logic [SW-1:0]                  div_qmod;

  logic [AW:0]                    pos_inc;
  logic [AW-1:0]                  pos_wrap;
  logic [AW:0]                    fetch_inc;
  logic [AW-1:0]                  fetch_wrap;
  logic [12:0]                    addr_ext;
  logic                           addr_ok;
  logic [PROD_W-1:0]              len_prod;
  logic [pov_pkg::COUNTER_W-1:0]  len_quot;
  logic [pov_pkg::SLOT_LEN_W-1:0] len_clamped;
  logic [10:0]                    slot_ext;
  logic [10:0]                    win_offs;
  logic                           win_hit;
  logic [pov_pkg::COLUMN_W-1:0]   column;

  // next text positions, wrapping at the store end before any read
  always_comb begin
    pos_inc    = {1'b0, text_position} + 1'b1;
    pos_wrap   = (pos_inc >= (AW+1)'(TEXT_DEPTH)) ? '0 : pos_inc[AW-1:0];
    fetch_inc  = {1'b0, fetch_addr} + 1'b1;
    fetch_wrap = (fetch_inc >= (AW+1)'(TEXT_DEPTH)) ? '0 : fetch_inc[AW-1:0];
    addr_ext   = {4'b0, cmd.text_address};
    addr_ok    = addr_ext < 13'(TEXT_DEPTH);
  end

  // slot length of an index pulse, held to 1 .. SLOT_LENGTH_MAX
  always_comb begin
    len_prod = PROD_W'(counter) * PROD_W'(LEN_RECIP);
    len_quot = pov_pkg::COUNTER_W'(len_prod >> LEN_SHIFT);
    if (len_quot == '0) begin
      len_clamped = pov_pkg::SLOT_LEN_W'(1);
    end else if (len_quot > pov_pkg::COUNTER_W'(pov_pkg::SLOT_LENGTH_MAX)) begin
      len_clamped = pov_pkg::SLOT_LENGTH_MAX;
    end else begin
      len_clamped = len_quot[pov_pkg::SLOT_LEN_W-1:0];
    end
  end

  // window lookup for the finished slot
  always_comb begin
    slot_ext = 11'(div_qmod);
    win_offs = slot_ext - 11'(WINDOW_FIRST);
    win_hit  = (slot_ext >= 11'(WINDOW_FIRST)) && (win_offs < 11'(WINDOW_LEN));
    column   = win_hit ? cell_q[win_offs[IW-1:0]] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pov_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next         = state;
    counter_next       = counter;
    slot_length_next   = slot_length;
    text_position_next = text_position;
    fetch_addr_next    = fetch_addr;
    fetch_left_next    = fetch_left;
    clr_addr_next      = clr_addr;
    res_valid_next     = res_valid && !res_ready;
    res_next           = res;
    cmd_ready          = 1'b0;
    mem_we             = 1'b0;
    mem_waddr          = clr_addr;
    mem_wdata          = '0;
    rd_en              = 1'b0;
    rd_addr            = fetch_addr;
    push               = 1'b0;
    div_start          = 1'b0;
    div_dividend       = counter;
    div_divisor        = {1'b0, slot_length};

    case (state)
      pov_pkg::S_CLEAR: begin
        mem_we        = 1'b1;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == LAST_ADDR) begin
          state_next = pov_pkg::S_IDLE;
        end
      end
      pov_pkg::S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          state_next = pov_pkg::S_START;
          case (cmd.operation)
            pov_pkg::OP_TICK: begin
              counter_next = counter + 1'b1;
            end
            pov_pkg::OP_INDEX: begin
              counter_next     = '0;
              slot_length_next = len_clamped;
            end
            pov_pkg::OP_SCROLL: begin
              rd_en           = 1'b1;
              rd_addr         = pos_wrap;
              fetch_addr_next = pos_wrap;
              fetch_left_next = LW'(1);
              state_next      = pov_pkg::S_CHECK;
            end
            pov_pkg::OP_WRITE: begin
              mem_we    = addr_ok;
              mem_waddr = addr_ext[AW-1:0];
              mem_wdata = cmd.text_word;
            end
            pov_pkg::OP_RESTART: begin
              rd_en           = 1'b1;
              rd_addr         = '0;
              fetch_addr_next = '0;
              fetch_left_next = LW'(WINDOW_LEN);
              state_next      = pov_pkg::S_CHECK;
            end
            default: begin
            end
          endcase
        end
      end
      pov_pkg::S_CHECK: begin
        // a marker sends the text back to its start; word 0 is taken as is
        if (fetch_addr != '0 && rd_data == pov_pkg::END_MARKER) begin
          rd_en           = 1'b1;
          rd_addr         = '0;
          fetch_addr_next = '0;
        end else begin
          push               = 1'b1;
          text_position_next = fetch_addr;
          if (fetch_left == LW'(1)) begin
            state_next = pov_pkg::S_START;
          end else begin
            fetch_left_next = fetch_left - 1'b1;
            rd_en           = 1'b1;
            rd_addr         = fetch_wrap;
            fetch_addr_next = fetch_wrap;
          end
        end
      end
      pov_pkg::S_START: begin
        div_start  = 1'b1;
        state_next = pov_pkg::S_DIV;
      end
      pov_pkg::S_DIV: begin
        if (div_done) begin
          state_next = pov_pkg::S_EMIT;
        end
      end
      pov_pkg::S_EMIT: begin
        if (!res_valid || res_ready) begin
          res_valid_next      = 1'b1;
          res_next.led_column = column;
          res_next.slot_index = slot_ext[6:0];
          state_next          = pov_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pov_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter       <= '0;
      slot_length   <= pov_pkg::RESET_SLOT_LENGTH;
      text_position <= '0;
      clr_addr      <= '0;
      res_valid     <= 1'b0;
    end else begin
      counter       <= counter_next;
      slot_length   <= slot_length_next;
      text_position <= text_position_next;
      clr_addr      <= clr_addr_next;
      res_valid     <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    fetch_addr <= fetch_addr_next;
    fetch_left <= fetch_left_next;
    res        <= res_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      text_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data <= text_mem[rd_addr];
    end
  end

  // window cells: each takes its right neighbor, the last takes the new word
  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
    logic [pov_pkg::COLUMN_W-1:0] cell_in;
    if (i == WINDOW_LEN - 1) begin : g_last
      assign cell_in = rd_data;
    end else begin : g_inner
      assign cell_in = cell_q[i+1];
    end
    pov_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (push),
      .shift_in (cell_in),
      .value    (cell_q[i])
    );
  end

  pov_div #(
    .MOD (SLOT_COUNT)
  ) u_div (
    .clk          (clk),
    .rst          (rst),
    .start        (div_start),
    .dividend     (div_dividend),
    .divisor      (div_divisor),
    .done         (div_done),
    .quotient_mod (div_qmod)
  );

endmodule

@@ hdl/pov_chk.sv @@
// ----------------------------------------------------------------------------
// pov_chk
// Port-level checks of the scrolling column driver, bound to the top level.
// ----------------------------------------------------------------------------
module pov_chk #(
  parameter int SLOT_COUNT   = 100,
  parameter int WINDOW_FIRST = 30,
  parameter int WINDOW_LEN   = 30
) (
  input logic          clk,
  input logic          rst,
  input logic          cmd_valid,
  input logic          cmd_ready,
  input pov_pkg::cmd_t cmd,
  input logic          res_valid,
  input logic          res_ready,
  input pov_pkg::res_t res
);

  localparam bit NARROW_SLOTS = SLOT_COUNT <= 128;

  // a waiting result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  // block is busy right after it takes an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("ready stayed high after accept");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    res_valid && NARROW_SLOTS |-> int'(res.slot_index) < SLOT_COUNT)
    else $error("slot index out of range");

  // slots outside the text window are dark
  a_dark_outside: assert property (@(posedge clk) disable iff (rst)
    res_valid && NARROW_SLOTS &&
    (int'(res.slot_index) < WINDOW_FIRST ||
     int'(res.slot_index) >= WINDOW_FIRST + WINDOW_LEN)
    |-> res.led_column == '0)
    else $error("column lit outside window");

endmodule

bind pov_scrolling_column_driver pov_chk #(
  .SLOT_COUNT   (SLOT_COUNT),
  .WINDOW_FIRST (WINDOW_FIRST),
  .WINDOW_LEN   (WINDOW_LEN)
) u_chk (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_ready (cmd_ready),
  .cmd       (cmd),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);

@@ tb/pov_scrolling_column_driver_checker.sv @@
// ----------------------------------------------------------------------------
// pov_scrolling_column_driver_checker
// Watches both channels of the column driver, keeps its own copy of the
// rotation counter, slot length, window and text store, works out the result
// of every accepted item and compares the results in order as they come out.
// ----------------------------------------------------------------------------
module pov_scrolling_column_driver_checker #(
  parameter int SLOT_COUNT   = 100,
  parameter int TEXT_DEPTH   = 512,
  parameter int WINDOW_FIRST = 30,
  parameter int WINDOW_LEN   = 30
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  logic          cmd_ready,
  input  pov_pkg::cmd_t cmd,
  input  logic          res_valid,
  input  logic          res_ready,
  input  pov_pkg::res_t res,
  output int            fail_count,
  output int            pending
);

  logic [pov_pkg::COUNTER_W-1:0]  rotation;
  logic [pov_pkg::SLOT_LEN_W-1:0] slot_len;
  logic [pov_pkg::COLUMN_W-1:0]   window [WINDOW_LEN];
  logic [pov_pkg::COLUMN_W-1:0]   text_mem [TEXT_DEPTH];
  int unsigned                    text_pos;
  pov_pkg::res_t                  column_q [$];
  int                             mismatches;
  int                             result_count;

  // applies one item to the display state and returns the column it shows
  function automatic pov_pkg::res_t advance_display(input pov_pkg::cmd_t c);
    int unsigned   len;
    int unsigned   j;
    int            slot;
    int            i;
    pov_pkg::res_t r;
    case (c.operation)
      pov_pkg::OP_TICK: rotation = rotation + 1'b1;
      pov_pkg::OP_INDEX: begin
        len = int'(rotation) / SLOT_COUNT;
        if (len < 1) len = 1;
        if (len > pov_pkg::SLOT_LENGTH_MAX) len = pov_pkg::SLOT_LENGTH_MAX;
        slot_len = pov_pkg::SLOT_LEN_W'(len);
        rotation = '0;
      end
      pov_pkg::OP_SCROLL: begin
        for (i = 0; i + 1 < WINDOW_LEN; i++) window[i] = window[i+1];
        text_pos++;
        // end of store is checked before the store is read
        if (text_pos >= TEXT_DEPTH) text_pos = 0;
        else if (text_mem[text_pos] == pov_pkg::END_MARKER) text_pos = 0;
        window[WINDOW_LEN-1] = text_mem[text_pos];
      end
      pov_pkg::OP_WRITE: begin
        if (c.text_address < TEXT_DEPTH) text_mem[c.text_address] = c.text_word;
      end
      pov_pkg::OP_RESTART: begin
        j = 0;
        for (i = 0; i < WINDOW_LEN; i++) begin
          if (j >= TEXT_DEPTH || text_mem[j] == pov_pkg::END_MARKER) j = 0;
          window[i] = text_mem[j];
          j++;
        end
        text_pos = j - 1;
      end
      default: ;
    endcase
    slot = (int'(rotation) / int'(slot_len)) % SLOT_COUNT;
    if (slot >= WINDOW_FIRST && slot - WINDOW_FIRST < WINDOW_LEN)
      r.led_column = window[slot-WINDOW_FIRST];
    else
      r.led_column = '0;
    r.slot_index = 7'(slot);
    return r;
  endfunction

  always @(posedge clk) begin
    pov_pkg::res_t want;
    int            k;
    if (rst) begin
      rotation = '0;
      slot_len = pov_pkg::RESET_SLOT_LENGTH;
      for (k = 0; k < WINDOW_LEN; k++) window[k] = '0;
      for (k = 0; k < TEXT_DEPTH; k++) text_mem[k] = '0;
      text_pos = 0;
      column_q.delete();
      mismatches = 0;
      result_count = 0;
    end else begin
      if (res_valid && res_ready) begin
        result_count++;
        if (column_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: column %h slot %0d arrived with no item outstanding",
                     result_count, res.led_column, res.slot_index);
        end else begin
          want = column_q.pop_front();
          if (res.led_column !== want.led_column || res.slot_index !== want.slot_index) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected column %h slot %0d, got column %h slot %0d",
                       result_count, want.led_column, want.slot_index,
                       res.led_column, res.slot_index);
          end
        end
      end
      if (cmd_valid && cmd_ready) column_q.push_back(advance_display(cmd));
    end
    fail_count <= mismatches;
    pending    <= column_q.size();
  end

endmodule

@@ tb/pov_scrolling_column_driver_test.sv @@
// ----------------------------------------------------------------------------
// pov_scrolling_column_driver_test
// Drives the column driver with directed items and then with random
// revolutions (index pulse followed by ticks mixed with scrolls, text writes,
// restarts and unused operations), with random idling on both channels, a
// long output stall and a long scroll run through the whole text store.
// ----------------------------------------------------------------------------
module pov_scrolling_column_driver_test;

  localparam int TEXT_DEPTH  = 512;
  localparam int QUIET_LIMIT = 5000;

  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_B = 3'd6;
  localparam logic [2:0] OP_SPARE_C = 3'd7;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          cmd_valid = 1'b0;
  logic          cmd_ready;
  pov_pkg::cmd_t cmd       = '0;
  logic          res_valid;
  logic          res_ready = 1'b0;
  pov_pkg::res_t res;

  int fail_count;
  int pending;

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int hold_request       = 0;
  int hold_left          = 0;
  int quiet_cycles       = 0;
  int items_sent         = 0;
  bit marker_at [TEXT_DEPTH];

  always #5 clk = ~clk;

  pov_scrolling_column_driver u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  pov_scrolling_column_driver_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // result side: random stalls, plus a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("pov_scrolling_column_driver: mismatch");
      $finish;
    end
  end

  function automatic pov_pkg::cmd_t random_cmd(input logic [2:0] op);
    pov_pkg::cmd_t c;
    c.operation    = op;
    c.text_address = 9'($urandom);
    c.text_word    = 16'($urandom);
    return c;
  endfunction

  // builds a text write and remembers where end markers sit
  function automatic pov_pkg::cmd_t text_write(input logic [8:0] addr,
                                               input logic [15:0] word);
    pov_pkg::cmd_t c;
    c.operation    = pov_pkg::OP_WRITE;
    c.text_address = addr;
    c.text_word    = word;
    marker_at[addr] = (word == pov_pkg::END_MARKER);
    return c;
  endfunction

  task automatic send_item(input pov_pkg::cmd_t c);
    while ($urandom_range(99) < sender_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd       <= c;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_results_drained();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // one revolution: index pulse, then mostly ticks so the slot sweeps the window
  task automatic sweep_revolution(input int unsigned n);
    int unsigned   roll;
    int unsigned   pick;
    logic [8:0]    addr;
    logic [15:0]   word;
    send_item(random_cmd(pov_pkg::OP_INDEX));
    repeat (n) begin
      roll = $urandom_range(99);
      if (roll < 62) begin
        send_item(random_cmd(pov_pkg::OP_TICK));
      end else if (roll < 74) begin
        send_item(random_cmd(pov_pkg::OP_SCROLL));
      end else if (roll < 86) begin
        pick = $urandom_range(15);
        word = (pick < 2) ? pov_pkg::END_MARKER : (pick == 2) ? 16'h0000 :
               (pick == 3) ? 16'hFFFF : 16'($urandom);
        addr = ($urandom_range(7) == 0) ? 9'($urandom) : 9'($urandom_range(47));
        send_item(text_write(addr, word));
      end else if (roll < 92) begin
        send_item(random_cmd(pov_pkg::OP_RESTART));
      end else if (roll < 96) begin
        send_item(random_cmd(OP_SPARE_A + 3'($urandom_range(2))));
      end else begin
        send_item(random_cmd(pov_pkg::OP_INDEX));
      end
    end
  endtask

  initial begin
    int idle_set [4]  = '{0, 75, 0, 28};
    int stall_set [4] = '{0, 0, 75, 28};
    int phase_end;
    int scrolls;
    int unsigned roll;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed items
    send_item(pov_pkg::cmd_t'{pov_pkg::OP_TICK, 9'h1FF, 16'hFFFF});
    send_item(pov_pkg::cmd_t'{OP_SPARE_A, 9'h000, 16'h0000});
    send_item(pov_pkg::cmd_t'{OP_SPARE_B, 9'h0AA, 16'h5555});
    send_item(pov_pkg::cmd_t'{OP_SPARE_C, 9'h1FF, 16'hFFFF});
    send_item(text_write(9'd0, 16'hFFFF));
    send_item(text_write(9'd511, 16'h0001));
    send_item(text_write(9'd1, 16'hA5A5));
    send_item(text_write(9'd3, 16'h0000));
    send_item(text_write(9'd2, pov_pkg::END_MARKER));
    send_item(random_cmd(pov_pkg::OP_RESTART));
    send_item(random_cmd(pov_pkg::OP_SCROLL));
    send_item(random_cmd(pov_pkg::OP_SCROLL));
    // tiny period gives the slot length of one
    send_item(pov_pkg::cmd_t'{pov_pkg::OP_INDEX, 9'h000, 16'h0000});
    send_item(random_cmd(pov_pkg::OP_TICK));
    send_item(random_cmd(pov_pkg::OP_TICK));
    send_item(text_write(9'd511, pov_pkg::END_MARKER));
    send_item(random_cmd(pov_pkg::OP_RESTART));
    send_item(random_cmd(pov_pkg::OP_SCROLL));

    for (int p = 0; p < 4; p++) begin
      sender_idle_pct    = idle_set[p];
      receiver_stall_pct = stall_set[p];
      phase_end = items_sent + 180;
      while (items_sent < phase_end) sweep_revolution($urandom_range(40, 160));
    end

    // long output stall while items keep coming, then let everything drain
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_request       = 400;
    sweep_revolution(30);
    wait_results_drained();

    // clear end markers so a scroll run reaches the end of the store
    for (int a = 0; a < TEXT_DEPTH; a++)
      if (marker_at[a]) send_item(text_write(9'(a), 16'hC3C3 ^ 16'(a)));
    send_item(random_cmd(pov_pkg::OP_RESTART));
    scrolls = 0;
    while (scrolls < 520) begin
      roll = $urandom_range(99);
      if (roll < 70) begin
        send_item(random_cmd(pov_pkg::OP_SCROLL));
        scrolls++;
      end else if (roll < 99) begin
        send_item(random_cmd(pov_pkg::OP_TICK));
      end else begin
        send_item(random_cmd(pov_pkg::OP_INDEX));
      end
    end

    wait_results_drained();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("pov_scrolling_column_driver: match");
    else
      $display("pov_scrolling_column_driver: mismatch");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/pov_pkg.sv
hdl/pov_cell.sv
hdl/pov_div.sv
hdl/pov_scrolling_column_driver.sv
hdl/pov_chk.sv
tb/pov_scrolling_column_driver_checker.sv
tb/pov_scrolling_column_driver_test.sv
